@@ hdl/scs_pkg.sv @@
// Shared constants and word types for the sine/cosine series core.
package scs_pkg;

    // Number of series terms after the leading term.
    localparam int SERIES_TERMS = 8;

    // Angle constants in Q8.56, truncated.
    localparam logic [63:0] PI_Q56      = 64'h03243F6A8885A308;
    localparam logic [63:0] HALF_PI_Q56 = 64'h01921FB54442D184;
    localparam logic [63:0] TWO_PI_Q56  = 64'h06487ED5110B4611;

    // Largest widened angle magnitude is 2^63; enough quotient bits to reduce it.
    localparam int RED_STEPS = $clog2((64'h8000000000000000 / TWO_PI_Q56) + 64'd1);

    localparam int X_W    = 31;  // folded magnitude, Q1.30 unsigned
    localparam int X2_W   = 32;  // x squared, Q2.30 unsigned
    localparam int TERM_W = 32;  // series term, Q2.30 unsigned
    localparam int V_W    = 34;  // term times x squared, before division
    localparam int RCP_W  = 32;  // reciprocal of a term divisor, scaled by 2^32
    localparam int SUM_W  = 36;  // signed running sum
    localparam int DIV_W  = $clog2(2 * SERIES_TERMS * (2 * SERIES_TERMS + 1) + 1);
    localparam int OUT_W  = 32;

    localparam logic [TERM_W-1:0] ONE_Q30 = TERM_W'(32'h40000000);

    // Word in the range reduction stages.
    typedef struct packed {
        logic [63:0] rem;   // magnitude remainder, Q8.56
        logic        sgn;   // sign of the original angle
    } red_t;

    // Word in the series stages.
    typedef struct packed {
        logic [X2_W-1:0]         x2;
        logic [TERM_W-1:0]       term_s;
        logic [TERM_W-1:0]       term_c;
        logic signed [SUM_W-1:0] sum_s;
        logic signed [SUM_W-1:0] sum_c;
        logic                    neg;    // negate sine
        logic                    fold;   // negate cosine
    } ser_t;

endpackage

@@ hdl/scs_reduce_step.sv @@
// One restoring step of the angle remainder by a multiple of 2*pi.
module scs_reduce_step (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  scs_pkg::red_t      in_data,
    input  logic [63:0]        multiple,
    output logic               out_valid,
    input  logic               out_ready,
    output scs_pkg::red_t      out_data
);

    logic          valid_reg;
    scs_pkg::red_t data_reg;
    scs_pkg::red_t data_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        if (in_data.rem >= multiple) begin
            data_next.rem = in_data.rem - multiple;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/scs_fold.sv @@
// Move the remainder into [-pi, pi], fold into [0, pi/2] and square it.
module scs_fold (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  scs_pkg::red_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output scs_pkg::ser_t out_data
);

    logic                        f1_valid_reg;
    logic [63:0]                 f1_m_reg;
    logic                        f1_neg_reg;
    logic                        f2_valid_reg;
    logic [scs_pkg::X_W-1:0]     f2_x_reg;
    logic                        f2_neg_reg;
    logic                        f2_fold_reg;
    logic                        f3_valid_reg;
    scs_pkg::ser_t               f3_reg;

    logic                        f1_ready;
    logic                        f2_ready;
    logic                        f3_ready;
    logic                        gt_pi;
    logic [63:0]                 f1_m_next;
    logic                        f1_neg_next;
    logic                        gt_half;
    logic [63:0]                 mf;
    logic [2*scs_pkg::X_W-1:0]   xx;
    scs_pkg::ser_t               f3_next;

    assign f3_ready = !f3_valid_reg || out_ready;
    assign f2_ready = !f2_valid_reg || f3_ready;
    assign f1_ready = !f1_valid_reg || f2_ready;
    assign in_ready = f1_ready;

    // Past pi the angle wraps to the other sign.
    always_comb begin
        gt_pi       = in_data.rem > scs_pkg::PI_Q56;
        f1_m_next   = gt_pi ? (scs_pkg::TWO_PI_Q56 - in_data.rem) : in_data.rem;
        f1_neg_next = (in_data.sgn && (in_data.rem != 64'd0)) ^ gt_pi;
    end

    always_comb begin
        gt_half = f1_m_reg > scs_pkg::HALF_PI_Q56;
        mf      = gt_half ? (scs_pkg::PI_Q56 - f1_m_reg) : f1_m_reg;
    end

    always_comb begin
        xx              = (2*scs_pkg::X_W)'(f2_x_reg) * (2*scs_pkg::X_W)'(f2_x_reg);
        f3_next.x2      = xx[30 +: scs_pkg::X2_W];
        f3_next.term_s  = scs_pkg::TERM_W'(f2_x_reg);
        f3_next.term_c  = scs_pkg::ONE_Q30;
        f3_next.sum_s   = $signed(scs_pkg::SUM_W'(f2_x_reg));
        f3_next.sum_c   = $signed(scs_pkg::SUM_W'(scs_pkg::ONE_Q30));
        f3_next.neg     = f2_neg_reg;
        f3_next.fold    = f2_fold_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else begin
            if (f1_ready) begin
                f1_valid_reg <= in_valid;
            end
            if (f2_ready) begin
                f2_valid_reg <= f1_valid_reg;
            end
            if (f3_ready) begin
                f3_valid_reg <= f2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (f1_ready && in_valid) begin
            f1_m_reg   <= f1_m_next;
            f1_neg_reg <= f1_neg_next;
        end
        if (f2_ready && f1_valid_reg) begin
            f2_x_reg    <= mf[26 +: scs_pkg::X_W];
            f2_neg_reg  <= f1_neg_reg;
            f2_fold_reg <= gt_half;
        end
        if (f3_ready && f2_valid_reg) begin
            f3_reg <= f3_next;
        end
    end

    assign out_valid = f3_valid_reg;
    assign out_data  = f3_reg;

endmodule

@@ hdl/scs_term.sv @@
// One series term for both lanes: multiply, divide by a constant, accumulate.
module scs_term (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  scs_pkg::ser_t              in_data,
    input  logic [scs_pkg::DIV_W-1:0]  div_s,
    input  logic [scs_pkg::RCP_W-1:0]  rcp_s,
    input  logic [scs_pkg::DIV_W-1:0]  div_c,
    input  logic [scs_pkg::RCP_W-1:0]  rcp_c,
    input  logic                       sub,
    output logic                       out_valid,
    input  logic                       out_ready,
    output scs_pkg::ser_t              out_data
);

    localparam int V_W   = scs_pkg::V_W;
    localparam int Q_W   = V_W + scs_pkg::RCP_W;
    localparam int P_W   = V_W + scs_pkg::DIV_W;

    logic                 a_valid_reg;
    scs_pkg::ser_t        a_ser_reg;
    logic [V_W-1:0]       a_vs_reg;
    logic [V_W-1:0]       a_vc_reg;
    logic                 b_valid_reg;
    scs_pkg::ser_t        b_ser_reg;
    logic [V_W-1:0]       b_vs_reg;
    logic [V_W-1:0]       b_vc_reg;
    logic [V_W-1:0]       b_qs_reg;
    logic [V_W-1:0]       b_qc_reg;
    logic                 c_valid_reg;
    scs_pkg::ser_t        c_reg;

    logic                 a_ready;
    logic                 b_ready;
    logic                 c_ready;
    logic [63:0]          ps;
    logic [63:0]          pc;
    logic [Q_W-1:0]       qs;
    logic [Q_W-1:0]       qc;
    logic [scs_pkg::TERM_W-1:0] ts;
    logic [scs_pkg::TERM_W-1:0] tc;
    scs_pkg::ser_t        c_next;

    // Reciprocal estimate is low by at most two; fix it with the remainder.
    function automatic logic [scs_pkg::TERM_W-1:0] fix_quot(
        input logic [V_W-1:0]           v,
        input logic [V_W-1:0]           q,
        input logic [scs_pkg::DIV_W-1:0] d
    );
        logic [P_W-1:0] p;
        logic [V_W-1:0] r;
        logic [V_W-1:0] qq;
        p  = P_W'(q) * P_W'(d);
        r  = v - p[V_W-1:0];
        qq = q;
        if (r >= V_W'(d)) begin
            r  = r - V_W'(d);
            qq = qq + V_W'(1);
        end
        if (r >= V_W'(d)) begin
            qq = qq + V_W'(1);
        end
        return qq[scs_pkg::TERM_W-1:0];
    endfunction

    assign c_ready  = !c_valid_reg || out_ready;
    assign b_ready  = !b_valid_reg || c_ready;
    assign a_ready  = !a_valid_reg || b_ready;
    assign in_ready = a_ready;

    always_comb begin
        ps = 64'(in_data.term_s) * 64'(in_data.x2);
        pc = 64'(in_data.term_c) * 64'(in_data.x2);
        qs = Q_W'(a_vs_reg) * Q_W'(rcp_s);
        qc = Q_W'(a_vc_reg) * Q_W'(rcp_c);
    end

    always_comb begin
        ts            = fix_quot(b_vs_reg, b_qs_reg, div_s);
        tc            = fix_quot(b_vc_reg, b_qc_reg, div_c);
        c_next        = b_ser_reg;
        c_next.term_s = ts;
        c_next.term_c = tc;
        if (sub) begin
            c_next.sum_s = b_ser_reg.sum_s - $signed(scs_pkg::SUM_W'(ts));
            c_next.sum_c = b_ser_reg.sum_c - $signed(scs_pkg::SUM_W'(tc));
        end else begin
            c_next.sum_s = b_ser_reg.sum_s + $signed(scs_pkg::SUM_W'(ts));
            c_next.sum_c = b_ser_reg.sum_c + $signed(scs_pkg::SUM_W'(tc));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            if (a_ready) begin
                a_valid_reg <= in_valid;
            end
            if (b_ready) begin
                b_valid_reg <= a_valid_reg;
            end
            if (c_ready) begin
                c_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_ser_reg <= in_data;
            a_vs_reg  <= ps[30 +: V_W];
            a_vc_reg  <= pc[30 +: V_W];
        end
        if (b_ready && a_valid_reg) begin
            b_ser_reg <= a_ser_reg;
            b_vs_reg  <= a_vs_reg;
            b_vc_reg  <= a_vc_reg;
            b_qs_reg  <= qs[scs_pkg::RCP_W +: V_W];
            b_qc_reg  <= qc[scs_pkg::RCP_W +: V_W];
        end
        if (c_ready && b_valid_reg) begin
            c_reg <= c_next;
        end
    end

    assign out_valid = c_valid_reg;
    assign out_data  = c_reg;

endmodule

@@ hdl/sine_cosine_series_core.sv @@
// Top level of the pipelined fixed-point sine and cosine series core.
//
// Usage:
//   Input channel s_valid / s_ready / s_angle carries one angle word, signed
//   Q8.24 radians; every 32-bit pattern is legal. Output channel m_valid /
//   m_ready / m_sine_value / m_cosine_value returns both results of one angle
//   together, signed Q2.30, saturated to plus or minus one. Words leave in
//   the order they entered.
//   The pipeline runs through the input register, the restoring remainder
//   steps, the fold stages and the three stages per series term (multiply,
//   reciprocal multiply, correct and accumulate), then the output register.
//   Throughput is one word per cycle while m_ready does not stall the output.
//   Every stage has its own valid bit and loads whenever it is empty or its
//   successor loads, so bubbles close up and s_ready stays high while the
//   pipeline has an empty slot, even when a result waits on m_ready.
//   When the receiver stalls, the last register holds its word and the
//   pipeline fills behind it; nothing is dropped or repeated.
//   Synchronous active-low reset clears all valid bits; data needs none.
module sine_cosine_series_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [31:0]             s_angle,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [scs_pkg::OUT_W-1:0] m_sine_value,
    output logic signed [scs_pkg::OUT_W-1:0] m_cosine_value
);

    localparam int NS = scs_pkg::RED_STEPS;
    localparam int NT = scs_pkg::SERIES_TERMS;

    // Input stage: take the magnitude and widen to Q8.56.
    logic          in_valid_reg;
    scs_pkg::red_t in_reg;
    scs_pkg::red_t in_next;
    logic [32:0]   ang_ext;
    logic [32:0]   ang_mag;

    logic [NS:0]   red_v;
    logic [NS:0]   red_r;
    scs_pkg::red_t red_d [NS+1];

    logic [NT:0]   ser_v;
    logic [NT:0]   ser_r;
    scs_pkg::ser_t ser_d [NT+1];

    // Output register.
    logic                              m_valid_reg;
    logic signed [scs_pkg::OUT_W-1:0]  m_sine_reg;
    logic signed [scs_pkg::OUT_W-1:0]  m_cosine_reg;
    logic                              out_ready;

    // Clamp the sum to plus or minus one, then apply the sign.
    function automatic logic signed [scs_pkg::OUT_W-1:0] sat_sign(
        input logic signed [scs_pkg::SUM_W-1:0] sum,
        input logic                             neg
    );
        logic signed [scs_pkg::SUM_W-1:0] one;
        logic signed [scs_pkg::SUM_W-1:0] c;
        one = $signed(scs_pkg::SUM_W'(scs_pkg::ONE_Q30));
        c   = sum;
        if (sum > one) begin
            c = one;
        end
        if (sum < -one) begin
            c = -one;
        end
        if (neg) begin
            c = -c;
        end
        return c[scs_pkg::OUT_W-1:0];
    endfunction

    always_comb begin
        ang_ext     = {s_angle[31], s_angle};
        ang_mag     = s_angle[31] ? (~ang_ext + 33'd1) : ang_ext;
        in_next.rem = {ang_mag[31:0], 32'd0};
        in_next.sgn = s_angle[31];
    end

    assign s_ready = !in_valid_reg || red_r[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= in_next;
        end
    end

    assign red_v[0] = in_valid_reg;
    assign red_d[0] = in_reg;

    // Restoring remainder: subtract 2*pi times 2^j, highest j first.
    genvar gi;
    generate
        for (gi = 0; gi < NS; gi++) begin : g_red
            scs_reduce_step u_step (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (red_v[gi]),
                .in_ready  (red_r[gi]),
                .in_data   (red_d[gi]),
                .multiple  (scs_pkg::TWO_PI_Q56 << (NS - 1 - gi)),
                .out_valid (red_v[gi+1]),
                .out_ready (red_r[gi+1]),
                .out_data  (red_d[gi+1])
            );
        end
    endgenerate

    scs_fold u_fold (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (red_v[NS]),
        .in_ready  (red_r[NS]),
        .in_data   (red_d[NS]),
        .out_valid (ser_v[0]),
        .out_ready (ser_r[0]),
        .out_data  (ser_d[0])
    );

    // Term k divides by d*(d+1): d = 2k for sine, 2k-1 for cosine.
    genvar gk;
    generate
        for (gk = 1; gk <= NT; gk++) begin : g_term
            localparam int unsigned DS = (2 * gk) * (2 * gk + 1);
            localparam int unsigned DC = (2 * gk - 1) * (2 * gk);
            localparam logic [63:0] RS = (64'd1 << 32) / 64'(DS);
            localparam logic [63:0] RC = (64'd1 << 32) / 64'(DC);
            localparam logic        SUB = (gk % 2) == 1;

            scs_term u_term (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .in_valid  (ser_v[gk-1]),
                .in_ready  (ser_r[gk-1]),
                .in_data   (ser_d[gk-1]),
                .div_s     (scs_pkg::DIV_W'(DS)),
                .rcp_s     (RS[scs_pkg::RCP_W-1:0]),
                .div_c     (scs_pkg::DIV_W'(DC)),
                .rcp_c     (RC[scs_pkg::RCP_W-1:0]),
                .sub       (SUB),
                .out_valid (ser_v[gk]),
                .out_ready (ser_r[gk]),
                .out_data  (ser_d[gk])
            );
        end
    endgenerate

    // Output stage: saturate, sign and hold for the receiver.
    assign out_ready = !m_valid_reg || m_ready;
    assign ser_r[NT] = out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= ser_v[NT];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && ser_v[NT]) begin
            m_sine_reg   <= sat_sign(ser_d[NT].sum_s, ser_d[NT].neg);
            m_cosine_reg <= sat_sign(ser_d[NT].sum_c, ser_d[NT].fold);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_sine_value   = m_sine_reg;
    assign m_cosine_value = m_cosine_reg;

    // An empty output register means every stage can load.
    a_ready_when_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready with output register empty");

    a_sine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_sine_value <= 32'sh40000000) && (m_sine_value >= -32'sh40000000))
        else $error("sine result outside plus or minus one");

    a_cosine_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_cosine_value <= 32'sh40000000) && (m_cosine_value >= -32'sh40000000))
        else $error("cosine result outside plus or minus one");

endmodule
